// ===== sv/codepoint_to_glyph_lookup_unit_macros.svh =====
// assertion helpers for the glyph lookup unit
`ifndef CODEPOINT_TO_GLYPH_LOOKUP_UNIT_MACROS_SVH
`define CODEPOINT_TO_GLYPH_LOOKUP_UNIT_MACROS_SVH

// consequent checked in the cycle after the antecedent
`define CGLU_ASSERT_NEXT(label, ant, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
        else $error("glyph lookup unit: assertion failed");

// consequent checked in the same cycle as the antecedent
`define CGLU_ASSERT_SAME(label, ant, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
        else $error("glyph lookup unit: assertion failed");

`endif

// ===== sv/cglu_pkg.sv =====
`default_nettype none

package cglu_pkg;

    localparam int EXT_W = 40;

    typedef logic [EXT_W-1:0] ext_addr_t;

    localparam logic [1:0] CFG_TABLE_FORMAT    = 2'd0;
    localparam logic [1:0] CFG_SUBTABLE_OFFSET = 2'd1;
    localparam logic [1:0] CFG_BLOB_SIZE       = 2'd2;

    localparam logic [1:0] FMT_SEGMENTED = 2'd1;
    localparam logic [1:0] FMT_GROUPED   = 2'd2;

    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_LOOKUP = 1'b1;

    localparam int SEG_COUNT_OFS  = 6;
    localparam int SEG_ENDS_OFS   = 14;
    localparam int SEG_STARTS_OFS = 16;
    localparam int GRP_COUNT_OFS  = 12;
    localparam int GRP_BASE_OFS   = 16;
    localparam int GRP_END_OFS    = 4;
    localparam int GRP_GLYPH_OFS  = 8;

    typedef struct packed {
        logic      start;
        logic      wide;
        ext_addr_t addr;
    } rd_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] data;
    } rd_rsp_t;

endpackage

`default_nettype wire

// ===== sv/cglu_mem.sv =====
`default_nettype none

module cglu_mem
    import cglu_pkg::*;
#(
    parameter int FONT_BYTES = 65536
) (
    input  wire logic                          clk,
    input  wire logic                          we,
    input  wire logic [$clog2(FONT_BYTES)-1:0] waddr,
    input  wire logic [7:0]                    wdata,
    input  wire logic [$clog2(FONT_BYTES)-1:0] raddr,
    output logic      [7:0]                    rdata
);

    logic [7:0] mem [FONT_BYTES];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== sv/cglu_rd.sv =====
`default_nettype none

module cglu_rd
    import cglu_pkg::*;
#(
    parameter int FONT_BYTES = 65536
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic [16:0]                   blob_size,
    input  wire rd_req_t                       req,
    output rd_rsp_t                            rsp,
    output logic      [$clog2(FONT_BYTES)-1:0] raddr,
    input  wire logic [7:0]                    rdata
);

    localparam int AW = $clog2(FONT_BYTES);

    typedef enum logic {
        R_IDLE,
        R_BUSY
    } state_t;

    state_t          state_reg, state_next;
    logic [AW-1:0]   addr_reg, addr_next;
    logic [2:0]      len_reg, len_next;
    logic [2:0]      issue_reg, issue_next;
    logic [2:0]      recv_reg, recv_next;
    logic            pend_reg, pend_next;
    logic            done_reg, done_next;
    logic [31:0]     data_reg, data_next;
    ext_addr_t       lim;
    ext_addr_t       span_end;

    always_comb
    begin
        lim = (EXT_W'(blob_size) > EXT_W'(FONT_BYTES)) ? EXT_W'(FONT_BYTES)
                                                       : EXT_W'(blob_size);
        span_end = req.addr + (req.wide ? EXT_W'(4) : EXT_W'(2));
        raddr = addr_reg + AW'(issue_reg);

        state_next = state_reg;
        addr_next  = addr_reg;
        len_next   = len_reg;
        issue_next = issue_reg;
        recv_next  = recv_reg;
        pend_next  = 1'b0;
        done_next  = 1'b0;
        data_next  = data_reg;

        unique case (state_reg)
            R_IDLE:
            begin
                if (req.start)
                begin
                    data_next = '0;
                    if (span_end > lim)
                    begin
                        done_next = 1'b1;
                    end
                    else
                    begin
                        addr_next  = req.addr[AW-1:0];
                        len_next   = req.wide ? 3'd4 : 3'd2;
                        issue_next = '0;
                        recv_next  = '0;
                        state_next = R_BUSY;
                    end
                end
            end
            R_BUSY:
            begin
                if (issue_reg < len_reg)
                begin
                    pend_next  = 1'b1;
                    issue_next = issue_reg + 3'd1;
                end
                if (pend_reg)
                begin
                    data_next = {data_reg[23:0], rdata};
                    recv_next = recv_reg + 3'd1;
                    if (recv_reg == len_reg - 3'd1)
                    begin
                        done_next  = 1'b1;
                        state_next = R_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = R_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= R_IDLE;
            pend_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg  <= addr_next;
        len_reg   <= len_next;
        issue_reg <= issue_next;
        recv_reg  <= recv_next;
        data_reg  <= data_next;
    end

    assign rsp.done = done_reg;
    assign rsp.data = data_reg;

endmodule

`default_nettype wire

// ===== sv/cglu_ctl.sv =====
`default_nettype none

module cglu_ctl
    import cglu_pkg::*;
#(
    parameter int FONT_BYTES = 65536
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic                          cmd,
    input  wire logic [15:0]                   byte_addr,
    input  wire logic [7:0]                    byte_value,
    input  wire logic [31:0]                   code_point,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic      [31:0]                   glyph_index,
    input  wire logic [1:0]                    table_format,
    input  wire logic [15:0]                   subtable_offset,
    output rd_req_t                            rd_req,
    input  wire rd_rsp_t                       rd_rsp,
    output logic                               mem_we,
    output logic      [$clog2(FONT_BYTES)-1:0] mem_waddr,
    output logic      [7:0]                    mem_wdata
);

    localparam int AW = $clog2(FONT_BYTES);

    typedef enum logic [3:0] {
        S_IDLE,
        S_WAIT,
        S_F4_HDR,
        S_F4_END,
        S_F4_CMP_END,
        S_F4_CMP_START,
        S_F4_GOT_DELTA,
        S_F4_GOT_ROFF,
        S_F4_GOT_G,
        S_F12_HI,
        S_F12_MID,
        S_F12_REC,
        S_F12_GOT_S,
        S_F12_GOT_E,
        S_F12_GOT_G,
        S_DONE
    } state_t;

    state_t      state_reg, state_next;
    state_t      after_reg, after_next;
    rd_req_t     req_reg, req_next;
    logic [15:0] tbl_reg, tbl_next;
    logic [31:0] code_reg, code_next;
    logic [15:0] sb_reg, sb_next;
    logic [16:0] off_reg, off_next;
    ext_addr_t   starts_reg, starts_next;
    ext_addr_t   deltas_reg, deltas_next;
    ext_addr_t   ranges_reg, ranges_next;
    logic [15:0] first_reg, first_next;
    logic [15:0] delta_reg, delta_next;
    logic [32:0] lo_reg, lo_next;
    logic [32:0] hi_reg, hi_next;
    logic [32:0] mid_reg, mid_next;
    ext_addr_t   rec_reg, rec_next;
    logic [31:0] s_reg, s_next;
    logic [31:0] result_reg, result_next;
    logic        out_valid_reg, out_valid_next;
    logic [31:0] glyph_reg, glyph_next;
    ext_addr_t   waddr_ext;
    ext_addr_t   tbl_ext;
    ext_addr_t   sb_ext;
    ext_addr_t   mid_ext;
    logic [15:0] diff;

    always_comb
    begin
        waddr_ext = EXT_W'(byte_addr);
        mem_we    = (state_reg == S_IDLE) && in_valid && (cmd == CMD_WRITE) &&
                    (waddr_ext < EXT_W'(FONT_BYTES));
        mem_waddr = waddr_ext[AW-1:0];
        mem_wdata = byte_value;
        in_stall  = (state_reg != S_IDLE);

        tbl_ext = EXT_W'(tbl_reg);
        sb_ext  = EXT_W'(rd_rsp.data[15:0]);
        mid_ext = EXT_W'(mid_reg);
        diff    = code_reg[15:0] - first_reg;

        state_next     = state_reg;
        after_next     = after_reg;
        req_next       = req_reg;
        req_next.start = 1'b0;
        tbl_next       = tbl_reg;
        code_next      = code_reg;
        sb_next        = sb_reg;
        off_next       = off_reg;
        starts_next    = starts_reg;
        deltas_next    = deltas_reg;
        ranges_next    = ranges_reg;
        first_next     = first_reg;
        delta_next     = delta_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        mid_next       = mid_reg;
        rec_next       = rec_reg;
        s_next         = s_reg;
        result_next    = result_reg;
        out_valid_next = out_valid_reg && out_stall;
        glyph_next     = glyph_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && (cmd == CMD_LOOKUP))
                begin
                    code_next   = code_point;
                    tbl_next    = subtable_offset;
                    result_next = '0;
                    state_next  = S_DONE;
                    if (subtable_offset != '0)
                    begin
                        if (table_format == FMT_SEGMENTED && !(|code_point[31:16]))
                        begin
                            req_next.start = 1'b1;
                            req_next.wide  = 1'b0;
                            req_next.addr  = EXT_W'(subtable_offset) + EXT_W'(SEG_COUNT_OFS);
                            after_next     = S_F4_HDR;
                            state_next     = S_WAIT;
                        end
                        else if (table_format == FMT_GROUPED)
                        begin
                            req_next.start = 1'b1;
                            req_next.wide  = 1'b1;
                            req_next.addr  = EXT_W'(subtable_offset) + EXT_W'(GRP_COUNT_OFS);
                            after_next     = S_F12_HI;
                            state_next     = S_WAIT;
                        end
                    end
                end
            end
            S_WAIT:
            begin
                if (rd_rsp.done)
                begin
                    state_next = after_reg;
                end
            end
            S_F4_HDR:
            begin
                sb_next     = rd_rsp.data[15:0];
                off_next    = '0;
                starts_next = tbl_ext + EXT_W'(SEG_STARTS_OFS) + sb_ext;
                deltas_next = tbl_ext + EXT_W'(SEG_STARTS_OFS) + (sb_ext << 1);
                ranges_next = tbl_ext + EXT_W'(SEG_STARTS_OFS) + (sb_ext << 1) + sb_ext;
                state_next  = S_F4_END;
            end
            S_F4_END:
            begin
                if (off_reg >= {1'b0, sb_reg[15:1], 1'b0})
                begin
                    result_next = '0;
                    state_next  = S_DONE;
                end
                else
                begin
                    req_next.start = 1'b1;
                    req_next.wide  = 1'b0;
                    req_next.addr  = tbl_ext + EXT_W'(SEG_ENDS_OFS) + EXT_W'(off_reg);
                    after_next     = S_F4_CMP_END;
                    state_next     = S_WAIT;
                end
            end
            S_F4_CMP_END:
            begin
                if (code_reg[15:0] > rd_rsp.data[15:0])
                begin
                    off_next   = off_reg + 17'd2;
                    state_next = S_F4_END;
                end
                else
                begin
                    req_next.start = 1'b1;
                    req_next.wide  = 1'b0;
                    req_next.addr  = starts_reg + EXT_W'(off_reg);
                    after_next     = S_F4_CMP_START;
                    state_next     = S_WAIT;
                end
            end
            S_F4_CMP_START:
            begin
                first_next = rd_rsp.data[15:0];
                if (code_reg[15:0] < rd_rsp.data[15:0])
                begin
                    result_next = '0;
                    state_next  = S_DONE;
                end
                else
                begin
                    req_next.start = 1'b1;
                    req_next.wide  = 1'b0;
                    req_next.addr  = deltas_reg + EXT_W'(off_reg);
                    after_next     = S_F4_GOT_DELTA;
                    state_next     = S_WAIT;
                end
            end
            S_F4_GOT_DELTA:
            begin
                delta_next     = rd_rsp.data[15:0];
                req_next.start = 1'b1;
                req_next.wide  = 1'b0;
                req_next.addr  = ranges_reg + EXT_W'(off_reg);
                after_next     = S_F4_GOT_ROFF;
                state_next     = S_WAIT;
            end
            S_F4_GOT_ROFF:
            begin
                if (rd_rsp.data[15:0] == '0)
                begin
                    result_next = {16'd0, code_reg[15:0] + delta_reg};
                    state_next  = S_DONE;
                end
                else
                begin
                    req_next.start = 1'b1;
                    req_next.wide  = 1'b0;
                    req_next.addr  = ranges_reg + EXT_W'(off_reg) +
                                     EXT_W'(rd_rsp.data[15:0]) + (EXT_W'(diff) << 1);
                    after_next     = S_F4_GOT_G;
                    state_next     = S_WAIT;
                end
            end
            S_F4_GOT_G:
            begin
                if (rd_rsp.data[15:0] == '0)
                begin
                    result_next = '0;
                end
                else
                begin
                    result_next = {16'd0, rd_rsp.data[15:0] + delta_reg};
                end
                state_next = S_DONE;
            end
            S_F12_HI:
            begin
                hi_next    = {1'b0, rd_rsp.data};
                lo_next    = '0;
                state_next = S_F12_MID;
            end
            S_F12_MID:
            begin
                if (lo_reg >= hi_reg)
                begin
                    result_next = '0;
                    state_next  = S_DONE;
                end
                else
                begin
                    mid_next   = lo_reg + ((hi_reg - lo_reg) >> 1);
                    state_next = S_F12_REC;
                end
            end
            S_F12_REC:
            begin
                rec_next       = tbl_ext + EXT_W'(GRP_BASE_OFS) + (mid_ext << 3) + (mid_ext << 2);
                req_next.start = 1'b1;
                req_next.wide  = 1'b1;
                req_next.addr  = tbl_ext + EXT_W'(GRP_BASE_OFS) + (mid_ext << 3) + (mid_ext << 2);
                after_next     = S_F12_GOT_S;
                state_next     = S_WAIT;
            end
            S_F12_GOT_S:
            begin
                s_next         = rd_rsp.data;
                req_next.start = 1'b1;
                req_next.wide  = 1'b1;
                req_next.addr  = rec_reg + EXT_W'(GRP_END_OFS);
                after_next     = S_F12_GOT_E;
                state_next     = S_WAIT;
            end
            S_F12_GOT_E:
            begin
                if (code_reg < s_reg)
                begin
                    hi_next    = mid_reg;
                    state_next = S_F12_MID;
                end
                else if (code_reg > rd_rsp.data)
                begin
                    lo_next    = mid_reg + 33'd1;
                    state_next = S_F12_MID;
                end
                else
                begin
                    req_next.start = 1'b1;
                    req_next.wide  = 1'b1;
                    req_next.addr  = rec_reg + EXT_W'(GRP_GLYPH_OFS);
                    after_next     = S_F12_GOT_G;
                    state_next     = S_WAIT;
                end
            end
            S_F12_GOT_G:
            begin
                result_next = rd_rsp.data + (code_reg - s_reg);
                state_next  = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    glyph_next     = result_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            after_reg     <= S_IDLE;
            req_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            after_reg     <= after_next;
            req_reg       <= req_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tbl_reg    <= tbl_next;
        code_reg   <= code_next;
        sb_reg     <= sb_next;
        off_reg    <= off_next;
        starts_reg <= starts_next;
        deltas_reg <= deltas_next;
        ranges_reg <= ranges_next;
        first_reg  <= first_next;
        delta_reg  <= delta_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        mid_reg    <= mid_next;
        rec_reg    <= rec_next;
        s_reg      <= s_next;
        result_reg <= result_next;
        glyph_reg  <= glyph_next;
    end

    assign rd_req      = req_reg;
    assign out_valid   = out_valid_reg;
    assign glyph_index = glyph_reg;

endmodule

`default_nettype wire

// ===== sv/codepoint_to_glyph_lookup_unit.sv =====
// Maps a character code to a glyph index through a format 4 or format 12 character map
// held in an internal byte-wide font memory. A write request (cmd 0) stores one byte and
// gives no result; a lookup request (cmd 1) gives one result. All table reads go through
// the single read port of the font memory, one byte per cycle. A format 4 lookup scans the
// segments in order up to the match and then reads the fields of that segment; a format 12
// lookup does a binary search over the groups and reads the glyph field when a group
// matches. Lookups are handled one at a time; the next request is taken as soon as the
// result sits in the output register, even while that result still waits.
`default_nettype none

module codepoint_to_glyph_lookup_unit
    import cglu_pkg::*;
#(
    parameter int FONT_BYTES = 65536
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        cmd,
    input  wire logic [15:0] byte_addr,
    input  wire logic [7:0]  byte_value,
    input  wire logic [31:0] code_point,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic      [31:0] glyph_index,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [16:0] cfg_data
);

    localparam int AW = $clog2(FONT_BYTES);

    logic [1:0]    table_format_reg;
    logic [15:0]   subtable_offset_reg;
    logic [16:0]   blob_size_reg;
    rd_req_t       rd_req;
    rd_rsp_t       rd_rsp;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [7:0]    mem_wdata;
    logic [AW-1:0] mem_raddr;
    logic [7:0]    mem_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_format_reg    <= '0;
            subtable_offset_reg <= '0;
            blob_size_reg       <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_TABLE_FORMAT:    table_format_reg    <= cfg_data[1:0];
                CFG_SUBTABLE_OFFSET: subtable_offset_reg <= cfg_data[15:0];
                CFG_BLOB_SIZE:       blob_size_reg       <= cfg_data;
                default:             ;
            endcase
        end
    end

    cglu_ctl #(
        .FONT_BYTES (FONT_BYTES)
    ) u_ctl (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .cmd             (cmd),
        .byte_addr       (byte_addr),
        .byte_value      (byte_value),
        .code_point      (code_point),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .glyph_index     (glyph_index),
        .table_format    (table_format_reg),
        .subtable_offset (subtable_offset_reg),
        .rd_req          (rd_req),
        .rd_rsp          (rd_rsp),
        .mem_we          (mem_we),
        .mem_waddr       (mem_waddr),
        .mem_wdata       (mem_wdata)
    );

    cglu_rd #(
        .FONT_BYTES (FONT_BYTES)
    ) u_rd (
        .clk       (clk),
        .rst_n     (rst_n),
        .blob_size (blob_size_reg),
        .req       (rd_req),
        .rsp       (rd_rsp),
        .raddr     (mem_raddr),
        .rdata     (mem_rdata)
    );

    cglu_mem #(
        .FONT_BYTES (FONT_BYTES)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

endmodule

`default_nettype wire

// ===== sv/cglu_checker.sv =====
`default_nettype none

`include "codepoint_to_glyph_lookup_unit_macros.svh"

module cglu_checker
    import cglu_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_stall,
    input wire logic        cmd,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic [31:0] glyph_index
);

    `CGLU_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(glyph_index))
    `CGLU_ASSERT_NEXT(a_lookup_busy, in_valid && !in_stall && cmd == CMD_LOOKUP, in_stall)
    `CGLU_ASSERT_NEXT(a_write_free, in_valid && !in_stall && cmd == CMD_WRITE, !in_stall)
    `CGLU_ASSERT_SAME(a_result_after_busy, $rose(out_valid), $past(in_stall))

endmodule

bind codepoint_to_glyph_lookup_unit cglu_checker u_chk (.*);

`default_nettype wire
